// ===== rtl/smm_pkg.sv =====
package smm_pkg;

    localparam int MAX_DIM_DEF = 16;

    localparam int TYPE_W = 2;
    localparam int IDX_W  = 4;
    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int OUT_W  = 38;
    localparam int DIM_W  = 5;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

    localparam logic [TYPE_W-1:0] REQ_WR_A = TYPE_W'(0);
    localparam logic [TYPE_W-1:0] REQ_WR_B = TYPE_W'(1);
    localparam logic [TYPE_W-1:0] REQ_RD   = TYPE_W'(2);

    typedef struct packed {
        logic clear;
        logic issue;
        logic last;
    } t_mac_ctrl;

endpackage

// ===== rtl/square_matrix_multiply.sv =====
// Square matrix multiply over two on-chip stores of MAX_DIM by MAX_DIM unsigned
// Q2.14 elements. A write request (type 0 for A, 1 for B) stores one element;
// writes with row or column at or above MAX_DIM are dropped.
// A read request (type 2) returns the dot product of row i of A and column j
// of B over the dimension in use, as an unsigned value with 28 fraction bits.
// A read in range runs one multiply-accumulate per cycle, fed by one read
// port of each store, through the RAM read, product and accumulate registers.
// A read whose row or column is outside the dimension in use returns zero.
// Type 3 is dropped. New requests are stalled while a read is in progress;
// the finished result sits in an output register, so the next request is
// taken while it waits. dim_in_use is to be written through the config port
// only while idle; the block itself does not enforce it. Values above MAX_DIM
// are treated as MAX_DIM. Store entries are undefined until written.
module square_matrix_multiply #(
    parameter int MAX_DIM = smm_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [smm_pkg::TYPE_W-1:0]    i_req_type,
    input  logic [smm_pkg::IDX_W-1:0]     i_row_index,
    input  logic [smm_pkg::IDX_W-1:0]     i_col_index,
    input  logic [smm_pkg::ELEM_W-1:0]    i_element_value,

    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [smm_pkg::OUT_W-1:0]     o_product_value,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [smm_pkg::DIM_W-1:0]     i_cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = AW + smm_pkg::IDX_W + smm_pkg::DIM_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH,
        S_FIN
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [smm_pkg::DIM_W-1:0]     r_dim;
    logic [smm_pkg::DIM_W-1:0]     r_dim_act;
    logic [smm_pkg::DIM_W-1:0]     r_k;
    logic [smm_pkg::IDX_W-1:0]     r_row;
    logic [smm_pkg::IDX_W-1:0]     r_col;
    logic                          r_out_valid;
    logic [smm_pkg::OUT_W-1:0]     r_out_data;

    logic                          in_accept;
    logic                          wr_in_range;
    logic                          rd_in_range;
    logic [smm_pkg::DIM_W-1:0]     dim_act;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 a_rd_addr;
    logic [AW-1:0]                 b_rd_addr;
    logic                          k_last;
    logic                          out_free;
    logic                          wr_a_en;
    logic                          wr_b_en;
    logic [smm_pkg::ELEM_W-1:0]    a_data;
    logic [smm_pkg::ELEM_W-1:0]    b_data;
    logic [smm_pkg::OUT_W-1:0]     acc;
    logic                          mac_done;
    smm_pkg::t_mac_ctrl            mac_ctrl;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign in_accept   = i_valid & ~o_stall;

    assign dim_act = (32'(r_dim) > MAX_DIM) ? smm_pkg::DIM_W'(MAX_DIM) : r_dim;

    assign wr_in_range = (32'(i_row_index) < MAX_DIM) && (32'(i_col_index) < MAX_DIM);
    assign rd_in_range = (32'(i_row_index) < 32'(dim_act))
                      && (32'(i_col_index) < 32'(dim_act));

    assign wr_addr   = AW'(XW'(i_row_index) * XW'(MAX_DIM) + XW'(i_col_index));
    assign a_rd_addr = AW'(XW'(r_row) * XW'(MAX_DIM) + XW'(r_k));
    assign b_rd_addr = AW'(XW'(r_k) * XW'(MAX_DIM) + XW'(r_col));

    assign k_last   = (32'(r_k) + 1 == 32'(r_dim_act));
    assign out_free = ~r_out_valid | ~i_stall;

    assign wr_a_en = in_accept & (i_req_type == smm_pkg::REQ_WR_A) & wr_in_range;
    assign wr_b_en = in_accept & (i_req_type == smm_pkg::REQ_WR_B) & wr_in_range;

    assign mac_ctrl.clear = in_accept & (i_req_type == smm_pkg::REQ_RD);
    assign mac_ctrl.issue = (r_state == S_RUN);
    assign mac_ctrl.last  = k_last;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && i_req_type == smm_pkg::REQ_RD) begin
                    n_state = rd_in_range ? S_RUN : S_FIN;
                end
            end
            S_RUN: begin
                if (k_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (mac_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dim       <= smm_pkg::DIM_RESET;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_dim <= i_cfg_data;
            end
            // Load the result when the output register is free, else drop it on take.
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_RUN) begin
                r_k <= r_k + 1'b1;
            end else begin
                r_k <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_row     <= i_row_index;
            r_col     <= i_col_index;
            r_dim_act <= dim_act;
        end
        if (r_state == S_FIN && out_free) begin
            r_out_data <= acc;
        end
    end

    smm_ram #(
        .WIDTH (smm_pkg::ELEM_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_a_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_element_value),
        .i_rd_en   (mac_ctrl.issue),
        .i_rd_addr (a_rd_addr),
        .o_rd_data (a_data)
    );

    smm_ram #(
        .WIDTH (smm_pkg::ELEM_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_b_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_element_value),
        .i_rd_en   (mac_ctrl.issue),
        .i_rd_addr (b_rd_addr),
        .o_rd_data (b_data)
    );

    smm_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_a_data (a_data),
        .i_b_data (b_data),
        .o_acc    (acc),
        .o_done   (mac_done)
    );

    assign o_valid         = r_out_valid;
    assign o_product_value = r_out_data;

endmodule

// ===== rtl/smm_ram.sv =====
module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/smm_mac.sv =====
module smm_mac (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  smm_pkg::t_mac_ctrl             i_ctrl,
    input  logic [smm_pkg::ELEM_W-1:0]     i_a_data,
    input  logic [smm_pkg::ELEM_W-1:0]     i_b_data,
    output logic [smm_pkg::OUT_W-1:0]      o_acc,
    output logic                           o_done
);

    logic                          r_v1;
    logic                          r_last1;
    logic                          r_v2;
    logic                          r_last2;
    logic                          r_done;
    logic [smm_pkg::PROD_W-1:0]    r_prod;
    logic [smm_pkg::OUT_W-1:0]     r_acc;

    // Control pipe: r_v1 follows the RAM read register, r_v2 the product register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_last1 <= 1'b0;
            r_v2    <= 1'b0;
            r_last2 <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_v1    <= i_ctrl.issue;
            r_last1 <= i_ctrl.issue & i_ctrl.last;
            r_v2    <= r_v1;
            r_last2 <= r_last1;
            r_done  <= r_v2 & r_last2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= smm_pkg::PROD_W'(i_a_data) * smm_pkg::PROD_W'(i_b_data);
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + smm_pkg::OUT_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

// ===== verif/tb_square_matrix_multiply.sv =====
`timescale 1ns / 1ps

module tb_square_matrix_multiply;

    localparam int N_DIM       = smm_pkg::MAX_DIM_DEF;
    localparam int N_CELLS     = N_DIM * N_DIM;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_WAIT  = 40;
    localparam int PHASE_ITEMS = 235;
    localparam int HOLD_CYCLES = 600;

    // Request code that the block drops.
    localparam logic [smm_pkg::TYPE_W-1:0] REQ_UNUSED = smm_pkg::TYPE_W'(3);

    typedef struct packed {
        logic [smm_pkg::TYPE_W-1:0] kind;
        logic [smm_pkg::IDX_W-1:0]  row;
        logic [smm_pkg::IDX_W-1:0]  col;
        logic [smm_pkg::ELEM_W-1:0] value;
    } t_mm_req;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       o_stall;
    t_mm_req                    cur_req = '0;
    logic                       o_valid;
    logic                       out_stall = 1'b0;
    logic [smm_pkg::OUT_W-1:0]  o_product_value;
    logic                       cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [smm_pkg::DIM_W-1:0]  cfg_data = '0;

    square_matrix_multiply #(.MAX_DIM(N_DIM)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (in_valid),
        .o_stall         (o_stall),
        .i_req_type      (cur_req.kind),
        .i_row_index     (cur_req.row),
        .i_col_index     (cur_req.col),
        .i_element_value (cur_req.value),
        .o_valid         (o_valid),
        .i_stall         (out_stall),
        .o_product_value (o_product_value),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mirror of the block state, updated as requests are accepted.
    logic [smm_pkg::ELEM_W-1:0] a_mirror [N_CELLS];
    logic [smm_pkg::ELEM_W-1:0] b_mirror [N_CELLS];
    logic [smm_pkg::DIM_W-1:0]  dim_reg = smm_pkg::DIM_RESET;
    logic [smm_pkg::OUT_W-1:0]  exp_products [$];

    // Entries already loaded by the request stream, as seen by the generator.
    bit                a_loaded [N_CELLS];
    bit                b_loaded [N_CELLS];
    t_mm_req           pend_reqs [$];

    int unsigned       cyc_cnt = 0;
    int unsigned       err_cnt = 0;
    int unsigned       send_gap = 0;
    int unsigned       recv_gap = 0;
    int unsigned       hold_cnt = 0;
    int unsigned       results_seen = 0;
    bit                hold_done = 1'b0;
    logic              quiet;

    // While bits 10:9 of the cycle counter are both set, no new idle gaps are drawn on either side.
    assign quiet = (cyc_cnt[10:9] == 2'b11);

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [smm_pkg::ELEM_W-1:0] pick_elem();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20) return '1;
        if (r < 30) return '0;
        return smm_pkg::ELEM_W'($urandom_range(0, 65535));
    endfunction

    function automatic int unsigned active_dim(logic [smm_pkg::DIM_W-1:0] d);
        return (d > smm_pkg::DIM_W'(N_DIM)) ? N_DIM : int'(d);
    endfunction

    function automatic logic [smm_pkg::OUT_W-1:0] dot_row_col(int unsigned row,
                                                               int unsigned col);
        logic [smm_pkg::OUT_W-1:0] sum;
        int unsigned               d;
        sum = '0;
        d = active_dim(dim_reg);
        if (row < d && col < d) begin
            for (int unsigned k = 0; k < d; k++) begin
                sum += smm_pkg::OUT_W'(a_mirror[row * N_DIM + k])
                     * smm_pkg::OUT_W'(b_mirror[k * N_DIM + col]);
            end
        end
        return sum;
    endfunction

    task automatic apply_request(t_mm_req rq);
        case (rq.kind)
            smm_pkg::REQ_WR_A: a_mirror[rq.row * N_DIM + rq.col] = rq.value;
            smm_pkg::REQ_WR_B: b_mirror[rq.row * N_DIM + rq.col] = rq.value;
            smm_pkg::REQ_RD:   exp_products.push_back(dot_row_col(rq.row, rq.col));
            default: ;
        endcase
    endtask

    task automatic push_req(logic [smm_pkg::TYPE_W-1:0] kind, int unsigned row,
                            int unsigned col, logic [smm_pkg::ELEM_W-1:0] value);
        t_mm_req rq;
        rq.kind  = kind;
        rq.row   = smm_pkg::IDX_W'(row);
        rq.col   = smm_pkg::IDX_W'(col);
        rq.value = value;
        if (kind == smm_pkg::REQ_WR_A) a_loaded[rq.row * N_DIM + rq.col] = 1'b1;
        if (kind == smm_pkg::REQ_WR_B) b_loaded[rq.row * N_DIM + rq.col] = 1'b1;
        pend_reqs.push_back(rq);
    endtask

    // Random traffic for one setting: mostly reads preceded by the loads they need.
    task automatic gen_phase(int unsigned d, int unsigned count);
        int unsigned made;
        int unsigned r;
        int unsigned row;
        int unsigned col;
        made = 0;
        while (made < count) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                push_req(REQ_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                         smm_pkg::ELEM_W'($urandom_range(0, 65535)));
            end else if (r < 20) begin
                push_req($urandom_range(0, 1) ? smm_pkg::REQ_WR_B : smm_pkg::REQ_WR_A,
                         $urandom_range(0, 15), $urandom_range(0, 15), pick_elem());
                made++;
            end else begin
                if (d == 0 || r < 33) begin
                    row = $urandom_range(0, 15);
                    col = $urandom_range(0, 15);
                end else begin
                    row = $urandom_range(0, d - 1);
                    col = $urandom_range(0, d - 1);
                end
                if (row < d && col < d) begin
                    for (int unsigned k = 0; k < d; k++) begin
                        if (!a_loaded[row * N_DIM + k] || $urandom_range(0, 7) == 0) begin
                            push_req(smm_pkg::REQ_WR_A, row, k, pick_elem());
                            made++;
                        end
                        if (!b_loaded[k * N_DIM + col] || $urandom_range(0, 7) == 0) begin
                            push_req(smm_pkg::REQ_WR_B, k, col, pick_elem());
                            made++;
                        end
                    end
                end
                push_req(smm_pkg::REQ_RD, row, col,
                         smm_pkg::ELEM_W'($urandom_range(0, 65535)));
                made++;
            end
        end
    endtask

    task automatic wait_idle();
        while (pend_reqs.size() != 0 || in_valid || exp_products.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_dim(logic [smm_pkg::DIM_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        dim_reg = v;
    endtask

    // Request driver: present pending requests, with random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_stall) begin
                apply_request(cur_req);
            end
            if (!in_valid || !o_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pend_reqs.size() != 0) begin
                    cur_req  <= pend_reqs.pop_front();
                    in_valid <= 1'b1;
                    send_gap = quiet ? 0 : pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall.
    always @(posedge i_clk) begin
        logic [smm_pkg::OUT_W-1:0] want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_valid && !out_stall) begin
                results_seen++;
                if (exp_products.size() == 0) begin
                    $error("product_value: no result expected, actual %0h", o_product_value);
                    err_cnt++;
                end else begin
                    want = exp_products.pop_front();
                    if (o_product_value !== want) begin
                        $error("product_value mismatch: expected %0h, actual %0h",
                               want, o_product_value);
                        err_cnt++;
                    end
                end
            end
            // Hold off once for a long stretch so the block backs up into its input.
            if (!hold_done && results_seen == 20) begin
                hold_done = 1'b1;
                hold_cnt  = HOLD_CYCLES;
            end
            if (hold_cnt != 0) begin
                hold_cnt--;
                out_stall <= 1'b1;
            end else if (recv_gap != 0) begin
                recv_gap--;
                out_stall <= 1'b1;
            end else begin
                recv_gap = quiet ? 0 : pick_gap();
                out_stall <= (recv_gap != 0);
                if (recv_gap != 0) recv_gap--;
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [smm_pkg::DIM_W-1:0] phase_dims [8];
        phase_dims = '{smm_pkg::DIM_W'(16), smm_pkg::DIM_W'(0), smm_pkg::DIM_W'(31),
                       smm_pkg::DIM_W'(3), smm_pkg::DIM_W'(17), smm_pkg::DIM_W'(2),
                       smm_pkg::DIM_W'(8), smm_pkg::DIM_W'(1)};
        phase_dims[7] = smm_pkg::DIM_W'($urandom_range(1, 16));
        foreach (a_mirror[i]) begin
            a_mirror[i] = '0;
            b_mirror[i] = '0;
            a_loaded[i] = 1'b0;
            b_loaded[i] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed checks at dimension one.
        write_dim(smm_pkg::DIM_W'(1));
        push_req(smm_pkg::REQ_WR_A, 0, 0, '1);
        push_req(smm_pkg::REQ_WR_B, 0, 0, '1);
        push_req(smm_pkg::REQ_RD, 0, 0, '1);
        push_req(smm_pkg::REQ_RD, 15, 0, '0);
        push_req(smm_pkg::REQ_RD, 0, 15, '0);
        push_req(smm_pkg::REQ_RD, 15, 15, '1);
        push_req(REQ_UNUSED, 15, 15, '1);
        push_req(smm_pkg::REQ_WR_A, 15, 15, '1);
        push_req(smm_pkg::REQ_WR_B, 15, 15, '0);
        push_req(smm_pkg::REQ_WR_A, 0, 0, '0);
        push_req(smm_pkg::REQ_RD, 0, 0, '0);
        push_req(REQ_UNUSED, 0, 0, '0);
        push_req(smm_pkg::REQ_WR_A, 0, 0, smm_pkg::ELEM_W'(16'h8000));
        push_req(smm_pkg::REQ_WR_B, 0, 0, smm_pkg::ELEM_W'(16'h0001));
        push_req(smm_pkg::REQ_RD, 0, 0, smm_pkg::ELEM_W'(16'h5a5a));
        push_req(smm_pkg::REQ_RD, 1, 1, '0);
        wait_idle();

        foreach (phase_dims[p]) begin
            write_dim(phase_dims[p]);
            gen_phase(active_dim(phase_dims[p]), PHASE_ITEMS);
            wait_idle();
        end

        if (exp_products.size() != 0) begin
            $error("product_value: %0d results never arrived", exp_products.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/smm_pkg.sv
rtl/smm_ram.sv
rtl/smm_mac.sv
rtl/square_matrix_multiply.sv
verif/tb_square_matrix_multiply.sv
